@@ rtl/bfsc_pkg.sv @@
// Shared types, constants and the CRC-32 byte update for the frame synchronizer.
`default_nettype none

package bfsc_pkg;

    localparam int unsigned HEADER_BYTES  = 28;
    localparam int unsigned TRAILER_BYTES = 4;
    localparam int unsigned POS_W         = 17;
    localparam int unsigned MAXLEN_W      = 17;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [7:0]  SYNC0    = 8'hAA;
    localparam logic [7:0]  SYNC1    = 8'h44;
    localparam logic [7:0]  SYNC2    = 8'h12;

    localparam logic [MAXLEN_W-1:0] MAX_FRAME_RESET = 17'd16384;

    localparam logic [POS_W-1:0] POS_ID_LO  = 17'd4;
    localparam logic [POS_W-1:0] POS_ID_HI  = 17'd5;
    localparam logic [POS_W-1:0] POS_LEN_LO = 17'd8;
    localparam logic [POS_W-1:0] POS_LEN_HI = 17'd9;
    localparam logic [POS_W-1:0] POS_AFTER_SYNC = 17'd3;

    localparam logic [15:0] ID_RANGE   = 16'd43;
    localparam logic [15:0] ID_GPS_EPH = 16'd7;
    localparam logic [15:0] ID_BDS_EPH = 16'd1696;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HEAD = 2'd1,
        PH_BODY = 2'd2,
        PH_TAIL = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_RANGE = 2'd0,
        KIND_GPS   = 2'd1,
        KIND_BDS   = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [15:0] message_id;
        logic [15:0] body_length;
        logic [1:0]  message_kind;
        logic [31:0] computed_crc;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic kind_t kind_of(input logic [15:0] id);
        kind_t k;
        if (id == ID_RANGE)
        begin
            k = KIND_RANGE;
        end
        else if (id == ID_GPS_EPH)
        begin
            k = KIND_GPS;
        end
        else if (id == ID_BDS_EPH)
        begin
            k = KIND_BDS;
        end
        else
        begin
            k = KIND_OTHER;
        end
        return k;
    endfunction

    localparam logic [31:0] SYNC_CRC = crc_byte(crc_byte(crc_byte(32'd0, SYNC0), SYNC1), SYNC2);

endpackage

`default_nettype wire

@@ rtl/binary_log_frame_sync_crc32.sv @@
// Framed binary message synchronizer with CRC-32 check, top level.
// Usage:
//   Byte channel: data_byte with byte_valid/byte_ready; one word per accepted
//   byte of the raw receiver stream. Result channel: frame_status, message_id,
//   body_length, message_kind, computed_crc with result_valid/result_ready.
//   At most one result word per frame: good, CRC error, or too long (the
//   latter right after the 28th header byte, CRC then covers the header only).
//   cfg_wr_en/cfg_wr_data write max_frame_bytes; write only while idle.
// Timing:
//   A byte is registered in the input stage at acceptance and processed from
//   there when the output stage is free; the verdict is registered in the output
//   stage. One byte per cycle sustained while the output stage stays free.
// Reset:
//   rst_n clears the frame tracker to sync hunt, empties both stages and
//   sets max_frame_bytes to 16384.
// Stall:
//   While a result waits on result_ready, one more byte is held in the input
//   stage and byte_ready drops only when that stage is full as well.
`default_nettype none

module binary_log_frame_sync_crc32
    import bfsc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_ready,
    input  wire logic [7:0]          data_byte,
    input  wire logic                cfg_wr_en,
    input  wire logic [MAXLEN_W-1:0] cfg_wr_data,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output logic [1:0]               frame_status,
    output logic [15:0]              message_id,
    output logic [15:0]              body_length,
    output logic [1:0]               message_kind,
    output logic [31:0]              computed_crc
);

    logic [MAXLEN_W-1:0] max_frame_reg;
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                out_valid_reg;
    result_t             out_reg;

    logic    step;
    logic    emit;
    result_t result;
    logic    out_free;

    assign out_free   = !out_valid_reg || result_ready;
    assign step       = in_valid_reg && out_free;
    assign byte_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg <= MAX_FRAME_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_frame_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_ready)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            in_byte_reg <= data_byte;
        end
    end

    bfsc_frame u_frame (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .data_byte       (in_byte_reg),
        .max_frame_bytes (max_frame_reg),
        .emit            (emit),
        .result          (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && step && emit)
        begin
            out_reg <= result;
        end
    end

    assign result_valid = out_valid_reg;
    assign frame_status = out_reg.frame_status;
    assign message_id   = out_reg.message_id;
    assign body_length  = out_reg.body_length;
    assign message_kind = out_reg.message_kind;
    assign computed_crc = out_reg.computed_crc;

endmodule

`default_nettype wire

@@ rtl/bfsc_frame.sv @@
// Frame tracker: sync hunt, header capture, running CRC and verdict per word.
`default_nettype none

module bfsc_frame
    import bfsc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [7:0]          data_byte,
    input  wire logic [MAXLEN_W-1:0] max_frame_bytes,
    output logic                     emit,
    output result_t                  result
);

    phase_t           phase_reg, phase_next;
    logic [1:0]       sync_reg, sync_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      crc_reg, crc_next;
    logic [15:0]      id_reg, id_next;
    logic [15:0]      len_reg, len_next;
    logic [31:0]      rcrc_reg, rcrc_next;

    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] body_end;
    logic [POS_W-1:0] frame_len;
    logic [31:0]      crc_upd;
    logic [1:0]       sync_restart;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            sync_reg  <= 2'd0;
            pos_reg   <= '0;
            crc_reg   <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
            rcrc_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            sync_reg  <= sync_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            rcrc_reg  <= rcrc_next;
        end
    end

    always_comb
    begin
        pos_inc      = pos_reg + 17'd1;
        body_end     = POS_W'(HEADER_BYTES) + {1'b0, len_reg};
        frame_len    = body_end + POS_W'(TRAILER_BYTES);
        crc_upd      = crc_byte(crc_reg, data_byte);
        sync_restart = (data_byte == SYNC0) ? 2'd1 : 2'd0;

        phase_next = phase_reg;
        sync_next  = sync_reg;
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        rcrc_next  = rcrc_reg;
        emit       = 1'b0;
        result.frame_status = ST_GOOD;

        unique case (phase_reg)
            PH_HUNT:
            begin
                case (sync_reg)
                    2'd0:
                    begin
                        sync_next = sync_restart;
                    end
                    2'd1:
                    begin
                        sync_next = (data_byte == SYNC1) ? 2'd2 : sync_restart;
                    end
                    default:
                    begin
                        if (data_byte == SYNC2)
                        begin
                            crc_next   = SYNC_CRC;
                            id_next    = '0;
                            len_next   = '0;
                            rcrc_next  = '0;
                            pos_next   = POS_AFTER_SYNC;
                            sync_next  = 2'd0;
                            phase_next = PH_HEAD;
                        end
                        else
                        begin
                            sync_next = sync_restart;
                        end
                    end
                endcase
            end
            PH_HEAD:
            begin
                crc_next = crc_upd;
                pos_next = pos_inc;
                case (pos_reg)
                    POS_ID_LO:  id_next  = {id_reg[15:8], data_byte};
                    POS_ID_HI:  id_next  = {data_byte, id_reg[7:0]};
                    POS_LEN_LO: len_next = {len_reg[15:8], data_byte};
                    POS_LEN_HI: len_next = {data_byte, len_reg[7:0]};
                    default: ;
                endcase
                if (pos_inc >= POS_W'(HEADER_BYTES))
                begin
                    if (frame_len > max_frame_bytes)
                    begin
                        emit                = 1'b1;
                        result.frame_status = ST_TOO_LONG;
                        phase_next          = PH_HUNT;
                        sync_next           = 2'd0;
                        pos_next            = '0;
                    end
                    else
                    begin
                        phase_next = (len_reg == 16'd0) ? PH_TAIL : PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                crc_next = crc_upd;
                pos_next = pos_inc;
                if (pos_inc >= body_end)
                begin
                    phase_next = PH_TAIL;
                end
            end
            PH_TAIL:
            begin
                rcrc_next = {data_byte, rcrc_reg[31:8]};
                pos_next  = pos_inc;
                if (pos_inc >= frame_len)
                begin
                    emit                = 1'b1;
                    result.frame_status = (rcrc_next == crc_reg) ? ST_GOOD : ST_CRC_ERR;
                    phase_next          = PH_HUNT;
                    sync_next           = 2'd0;
                    pos_next            = '0;
                end
            end
            default: ;
        endcase

        result.message_id   = id_reg;
        result.body_length  = len_reg;
        result.message_kind = kind_of(id_reg);
        result.computed_crc = crc_next;
    end

endmodule

`default_nettype wire

@@ sim/binary_log_frame_sync_crc32_tb.sv @@
// Self-checking testbench for the CRC-32 framed binary message synchronizer.
module binary_log_frame_sync_crc32_tb;
    import bfsc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int WHOLE       = 32'h7FFF_FFFF;
    localparam int MAX_PRINTED = 100;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                byte_valid   = 1'b0;
    logic                byte_ready;
    logic [7:0]          data_byte    = 8'd0;
    logic                cfg_wr_en    = 1'b0;
    logic [MAXLEN_W-1:0] cfg_wr_data  = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic [1:0]          frame_status;
    logic [15:0]         message_id;
    logic [15:0]         body_length;
    logic [1:0]          message_kind;
    logic [31:0]         computed_crc;

    // frame tracker state
    phase_t              trk_phase   = PH_HUNT;
    int unsigned         sync_seen   = 0;
    int unsigned         frame_pos   = 0;
    logic [31:0]         run_crc     = '0;
    logic [15:0]         hdr_id      = '0;
    logic [15:0]         hdr_len     = '0;
    logic [31:0]         rx_crc      = '0;
    logic [MAXLEN_W-1:0] frame_limit = MAX_FRAME_RESET;

    result_t             verdict_q[$];
    result_t             oldest;
    int                  feed_idle_pct      = 0;
    int                  drain_stall_pct    = 0;
    int unsigned         bytes_accepted     = 0;
    int unsigned         verdicts_predicted = 0;
    int unsigned         mismatches         = 0;
    int unsigned         quiet_cycles       = 0;

    binary_log_frame_sync_crc32 DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .data_byte    (data_byte),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .frame_status (frame_status),
        .message_id   (message_id),
        .body_length  (body_length),
        .message_kind (message_kind),
        .computed_crc (computed_crc)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        repeat (8)
            r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
        return r;
    endfunction

    function automatic kind_t kind_for_id(input logic [15:0] id);
        case (id)
            ID_RANGE:   return KIND_RANGE;
            ID_GPS_EPH: return KIND_GPS;
            ID_BDS_EPH: return KIND_BDS;
            default:    return KIND_OTHER;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatches < MAX_PRINTED)
            $display("%0t mismatch %s: expected %h, got %h", $time, what, want, got);
        mismatches++;
    endtask

    task automatic close_frame(input status_t st);
        result_t r;
        r.frame_status = st;
        r.message_id   = hdr_id;
        r.body_length  = hdr_len;
        r.message_kind = kind_for_id(hdr_id);
        r.computed_crc = run_crc;
        verdict_q.push_back(r);
        verdicts_predicted++;
        trk_phase = PH_HUNT;
        sync_seen = 0;
        frame_pos = 0;
    endtask

    task automatic track_byte(input logic [7:0] b);
        case (trk_phase)
            PH_HUNT:
            begin
                if (sync_seen == 2 && b == SYNC2)
                begin
                    run_crc   = crc_step(crc_step(crc_step(32'd0, SYNC0), SYNC1), SYNC2);
                    hdr_id    = '0;
                    hdr_len   = '0;
                    rx_crc    = '0;
                    frame_pos = 3;
                    sync_seen = 0;
                    trk_phase = PH_HEAD;
                end
                else if (sync_seen == 1 && b == SYNC1)
                    sync_seen = 2;
                else
                    sync_seen = (b == SYNC0) ? 1 : 0;
            end
            PH_HEAD:
            begin
                run_crc = crc_step(run_crc, b);
                case (frame_pos)
                    POS_ID_LO:  hdr_id[7:0]   = b;
                    POS_ID_HI:  hdr_id[15:8]  = b;
                    POS_LEN_LO: hdr_len[7:0]  = b;
                    POS_LEN_HI: hdr_len[15:8] = b;
                    default: ;
                endcase
                frame_pos++;
                if (frame_pos >= HEADER_BYTES)
                begin
                    if (HEADER_BYTES + hdr_len + TRAILER_BYTES > frame_limit)
                        close_frame(ST_TOO_LONG);
                    else if (hdr_len == 0)
                        trk_phase = PH_TAIL;
                    else
                        trk_phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                run_crc = crc_step(run_crc, b);
                frame_pos++;
                if (frame_pos >= HEADER_BYTES + hdr_len)
                    trk_phase = PH_TAIL;
            end
            default:
            begin
                rx_crc = {b, rx_crc[31:8]};
                frame_pos++;
                if (frame_pos >= HEADER_BYTES + hdr_len + TRAILER_BYTES)
                begin
                    if (rx_crc == run_crc)
                        close_frame(ST_GOOD);
                    else
                        close_frame(ST_CRC_ERR);
                end
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n && byte_valid && byte_ready)
        begin
            bytes_accepted++;
            track_byte(data_byte);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (verdict_q.size() == 0)
                report_mismatch("word with no verdict pending", 32'd0, computed_crc);
            else
            begin
                oldest = verdict_q.pop_front();
                if (frame_status !== oldest.frame_status)
                    report_mismatch("frame_status", oldest.frame_status, frame_status);
                if (message_id !== oldest.message_id)
                    report_mismatch("message_id", oldest.message_id, message_id);
                if (body_length !== oldest.body_length)
                    report_mismatch("body_length", oldest.body_length, body_length);
                if (message_kind !== oldest.message_kind)
                    report_mismatch("message_kind", oldest.message_kind, message_kind);
                if (computed_crc !== oldest.computed_crc)
                    report_mismatch("computed_crc", oldest.computed_crc, computed_crc);
            end
        end
        result_ready <= ($urandom_range(99) >= drain_stall_pct);
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((byte_valid && byte_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < feed_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        do
            @(posedge clk);
        while (!byte_ready);
    endtask

    // builds a frame with a correct trailer unless bad_crc; sends its first keep bytes
    task automatic send_frame(input logic [15:0] id, input logic [15:0] len,
                              input bit bad_crc, input int keep);
        logic [7:0]  bytes_q[$];
        logic [31:0] crc;
        logic [31:0] flip;
        crc = '0;
        for (int i = 0; i < HEADER_BYTES + len; i++)
        begin
            case (i)
                0:       bytes_q.push_back(SYNC0);
                1:       bytes_q.push_back(SYNC1);
                2:       bytes_q.push_back(SYNC2);
                4:       bytes_q.push_back(id[7:0]);
                5:       bytes_q.push_back(id[15:8]);
                8:       bytes_q.push_back(len[7:0]);
                9:       bytes_q.push_back(len[15:8]);
                default: bytes_q.push_back(8'($urandom));
            endcase
            crc = crc_step(crc, bytes_q[i]);
        end
        flip = bad_crc ? (32'd1 << $urandom_range(31)) : 32'd0;
        for (int k = 0; k < 4; k++)
            bytes_q.push_back(8'((crc ^ flip) >> (8 * k)));
        for (int i = 0; i < bytes_q.size() && i < keep; i++)
            send_byte(bytes_q[i]);
    endtask

    task automatic drain_verdicts();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_frame_limit(input logic [MAXLEN_W-1:0] value);
        drain_verdicts();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        frame_limit = value;
    endtask

    task automatic test_sync_hunting();
        feed_idle_pct   = 27;
        drain_stall_pct = 27;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC1);
        send_byte(SYNC2);
        // partial match broken by a new AA
        send_byte(SYNC0);
        send_byte(SYNC1);
        send_frame(ID_RANGE, 16'd2, 1'b0, WHOLE);
        send_byte(SYNC0);
        send_frame(ID_GPS_EPH, 16'd1, 1'b0, WHOLE);
        send_byte(SYNC0);
        send_byte(SYNC1);
        send_byte(SYNC1);
        send_frame(16'd0, 16'd0, 1'b0, WHOLE);
    endtask

    task automatic test_frame_kinds();
        feed_idle_pct   = 0;
        drain_stall_pct = 0;
        send_frame(ID_BDS_EPH, 16'd0, 1'b0, WHOLE);
        send_frame(ID_RANGE, 16'd3, 1'b1, WHOLE);
        send_frame(16'hFFFF, 16'd5, 1'b0, WHOLE);
        send_frame(ID_GPS_EPH, 16'd0, 1'b1, WHOLE);
        send_frame(16'd1234, 16'd1, 1'b1, WHOLE);
    endtask

    task automatic test_length_limit();
        feed_idle_pct   = 0;
        drain_stall_pct = 0;
        set_frame_limit(17'd0);
        send_frame(ID_RANGE, 16'd0, 1'b0, WHOLE);
        set_frame_limit(17'd31);
        send_frame(ID_GPS_EPH, 16'd0, 1'b0, WHOLE);
        set_frame_limit(17'd32);
        send_frame(ID_BDS_EPH, 16'd0, 1'b0, WHOLE);
        send_frame(ID_RANGE, 16'd1, 1'b0, WHOLE);
        set_frame_limit(17'd65566);
        send_frame(ID_BDS_EPH, 16'hFFFF, 1'b0, HEADER_BYTES);
        set_frame_limit(17'd65567);
        send_frame(ID_BDS_EPH, 16'd24, 1'b0, WHOLE);
        set_frame_limit('1);
        send_frame(16'hABCD, 16'd40, 1'b1, WHOLE);
        set_frame_limit(MAX_FRAME_RESET);
        send_frame(ID_GPS_EPH, 16'd16353, 1'b0, HEADER_BYTES);
        send_frame(ID_RANGE, 16'd7, 1'b0, WHOLE);
    endtask

    task automatic test_random_traffic();
        int unsigned byte_mark;
        int unsigned verdict_mark;
        logic [15:0] id;
        logic [15:0] len;
        logic [7:0]  noise;
        int          pick;
        int          keep;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: set_frame_limit(MAX_FRAME_RESET);
                1: set_frame_limit(17'd80);
                2: set_frame_limit(17'd48);
                default: set_frame_limit(17'd65567);
            endcase
            feed_idle_pct   = (p == 1) ? 47 : (p == 3) ? 27 : 0;
            drain_stall_pct = (p == 2) ? 47 : (p == 3) ? 27 : 0;
            byte_mark    = bytes_accepted;
            verdict_mark = verdicts_predicted;
            while (bytes_accepted - byte_mark < 64 || verdicts_predicted - verdict_mark < 2)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                begin
                    case ($urandom_range(3))
                        0:       id = ID_RANGE;
                        1:       id = ID_GPS_EPH;
                        2:       id = ID_BDS_EPH;
                        default: id = 16'($urandom);
                    endcase
                    if ($urandom_range(99) < 85)
                        len = 16'($urandom_range(24));
                    else
                        len = 16'($urandom_range(120, 25));
                    keep = WHOLE;
                    if (pick >= 70)
                        keep = $urandom_range(HEADER_BYTES + len + 3, 1);
                    else if (HEADER_BYTES + len + TRAILER_BYTES > frame_limit
                             && $urandom_range(1))
                        keep = HEADER_BYTES;
                    send_frame(id, len, $urandom_range(99) < 20, keep);
                end
                else
                begin
                    repeat ($urandom_range(6, 1))
                    begin
                        case ($urandom_range(3))
                            0:       noise = SYNC0;
                            1:       noise = SYNC1;
                            2:       noise = SYNC2;
                            default: noise = 8'($urandom);
                        endcase
                        send_byte(noise);
                    end
                end
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_sync_hunting();
        test_frame_kinds();
        test_length_limit();
        test_random_traffic();
        drain_verdicts();
        repeat (16) @(posedge clk);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
